// ===== src/siphash_keyed_hash_defines.svh =====
// Assertion macros shared by the SipHash block.
`ifndef SIPHASH_KEYED_HASH_DEFINES_SVH
`define SIPHASH_KEYED_HASH_DEFINES_SVH

`ifndef SYNTHESIS

// Checked outside reset.
`define SH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define SH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define SH_ASSERT(lbl, prop, msg)
`define SH_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== src/siphash_pkg.sv =====
// Types, constants and round function of the SipHash block.
package siphash_pkg;

    localparam int MAX_ROUNDS = 8;
    localparam int CNT_W      = $clog2(MAX_ROUNDS + 1);
    localparam int WORD_W     = 64;
    localparam int TAIL_W     = 3;
    localparam int ROUND_W    = 4;
    localparam int LEN_W      = 8;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 64;
    localparam int IDX_W      = 2;

    // register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_KEY_LOW         = 2'd0,
        REG_KEY_HIGH        = 2'd1,
        REG_COMPRESS_ROUNDS = 2'd2,
        REG_FINAL_ROUNDS    = 2'd3
    } reg_index_t;

    localparam logic [WORD_W-1:0] IV0 = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] IV1 = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] IV2 = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] IV3 = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] FINAL_MARK = 64'h00000000000000ff;

    typedef logic [3:0][WORD_W-1:0] lanes_t;

    typedef struct packed {
        logic load;     // take the beat on s_tdata into the lanes
        logic fresh;    // beat starts a new message: lanes from key
        logic last;     // beat is the final, padded word
        logic round;    // run one SipRound this cycle
        logic xor_m;    // fold the word into v0 after the round
        logic xor_ff;   // mark finalization in v2
        logic capture;  // latch the hash into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic [ROUND_W-1:0] compress_rounds;
        logic [ROUND_W-1:0] final_rounds;
    } dp_status_t;

    function automatic logic [WORD_W-1:0] rotl64(logic [WORD_W-1:0] x, int n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    function automatic lanes_t sip_round(lanes_t v);
        logic [WORD_W-1:0] a, b, c, d;
        lanes_t r;
        a = v[0]; b = v[1]; c = v[2]; d = v[3];
        a = a + b; c = c + d;
        b = rotl64(b, 13); d = rotl64(d, 16);
        b = b ^ a; d = d ^ c;
        a = rotl64(a, 32);
        c = c + b; a = a + d;
        b = rotl64(b, 17); d = rotl64(d, 21);
        b = b ^ c; d = d ^ a;
        c = rotl64(c, 32);
        r[0] = a; r[1] = b; r[2] = c; r[3] = d;
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] sat_rounds(logic [ROUND_W-1:0] r);
        if (int'(r) > MAX_ROUNDS) begin
            return CNT_W'(MAX_ROUNDS);
        end
        return CNT_W'(r);
    endfunction

endpackage

// ===== src/siphash_dp.sv =====
// SipHash datapath: config registers, lanes, round unit, output register.
module siphash_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [siphash_pkg::IDX_W-1:0]     cfg_index,
    input  logic [siphash_pkg::WORD_W-1:0]    cfg_wdata,
    input  logic [siphash_pkg::S_TDATA_W-1:0] s_tdata,
    input  siphash_pkg::dp_cmd_t              cmd,
    output siphash_pkg::dp_status_t           status,
    output logic [siphash_pkg::M_TDATA_W-1:0] m_tdata
);
    import siphash_pkg::*;

    logic [WORD_W-1:0]  key_low_reg, key_high_reg;
    logic [ROUND_W-1:0] comp_rounds_reg, fin_rounds_reg;
    lanes_t             lanes_reg, lanes_next;
    logic [WORD_W-1:0]  m_reg, m_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [WORD_W-1:0]  hash_reg;

    logic [WORD_W-1:0]  word_in;
    logic [TAIL_W-1:0]  tail_in;
    logic [LEN_W-1:0]   len_base, total;
    logic [WORD_W-1:0]  tail_mask, block;
    lanes_t             base, pre, rnd, post;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg     <= '0;
            key_high_reg    <= '0;
            comp_rounds_reg <= ROUND_W'(2);
            fin_rounds_reg  <= ROUND_W'(4);
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_index))
                REG_KEY_LOW:         key_low_reg     <= cfg_wdata;
                REG_KEY_HIGH:        key_high_reg    <= cfg_wdata;
                REG_COMPRESS_ROUNDS: comp_rounds_reg <= cfg_wdata[ROUND_W-1:0];
                REG_FINAL_ROUNDS:    fin_rounds_reg  <= cfg_wdata[ROUND_W-1:0];
                default: ;
            endcase
        end
    end

    assign status.compress_rounds = comp_rounds_reg;
    assign status.final_rounds    = fin_rounds_reg;

    assign word_in = s_tdata[WORD_W-1:0];
    assign tail_in = s_tdata[WORD_W +: TAIL_W];

    always_comb begin
        len_base  = cmd.fresh ? '0 : len_reg;
        total     = len_base + LEN_W'(tail_in);
        tail_mask = (WORD_W'(1) << {tail_in, 3'b000}) - WORD_W'(1);
        block     = cmd.last ? ((word_in & tail_mask) | {total, {(WORD_W-LEN_W){1'b0}}})
                             : word_in;

        base[0] = key_low_reg  ^ IV0;
        base[1] = key_high_reg ^ IV1;
        base[2] = key_low_reg  ^ IV2;
        base[3] = key_high_reg ^ IV3;
        if (!cmd.fresh) begin
            base = lanes_reg;
        end

        if (cmd.load) begin
            pre      = base;
            pre[3]   = base[3] ^ block;
            m_next   = block;
            len_next = cmd.last ? '0 : len_base + LEN_W'(8);
        end else begin
            pre      = lanes_reg;
            m_next   = m_reg;
            len_next = len_reg;
        end

        rnd = cmd.round ? sip_round(pre) : pre;

        post = rnd;
        if (cmd.xor_m) begin
            post[0] = rnd[0] ^ m_next;
        end
        if (cmd.xor_ff) begin
            post[2] = rnd[2] ^ FINAL_MARK;
        end
        lanes_next = post;
    end

    always_ff @(posedge aclk) begin
        lanes_reg <= lanes_next;
        m_reg     <= m_next;
        len_reg   <= len_next;
        if (cmd.capture) begin
            hash_reg <= lanes_reg[0] ^ lanes_reg[1] ^ lanes_reg[2] ^ lanes_reg[3];
        end
    end

    assign m_tdata = hash_reg;

endmodule

// ===== src/siphash_ctrl.sv =====
// SipHash controller: sequences compression and finalization rounds.
`include "siphash_keyed_hash_defines.svh"
module siphash_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    input  logic                     s_tlast,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    input  siphash_pkg::dp_status_t  status,
    output siphash_pkg::dp_cmd_t     cmd
);
    import siphash_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMP,
        ST_FIN,
        ST_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             fresh_reg, fresh_next;
    logic             last_reg, last_next;
    logic             m_tvalid_reg, m_tvalid_next;

    logic [CNT_W-1:0] c_rounds, d_rounds;
    logic             accept, out_free;

    assign c_rounds = sat_rounds(status.compress_rounds);
    assign d_rounds = sat_rounds(status.final_rounds);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        fresh_next    = fresh_reg;
        last_next     = last_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    // first round runs in the accept cycle
                    cmd.load   = 1'b1;
                    cmd.fresh  = fresh_reg;
                    cmd.last   = s_tlast;
                    cmd.round  = (c_rounds != '0);
                    cmd.xor_m  = (c_rounds <= CNT_W'(1));
                    cmd.xor_ff = s_tlast && (c_rounds <= CNT_W'(1));
                    fresh_next = s_tlast;
                    last_next  = s_tlast;
                    if (c_rounds > CNT_W'(1)) begin
                        cnt_next   = c_rounds - CNT_W'(1);
                        state_next = ST_COMP;
                    end else if (s_tlast) begin
                        cnt_next   = d_rounds;
                        state_next = (d_rounds == '0) ? ST_OUT : ST_FIN;
                    end
                end
            end
            ST_COMP: begin
                cmd.round  = 1'b1;
                cmd.xor_m  = (cnt_reg == CNT_W'(1));
                cmd.xor_ff = last_reg && (cnt_reg == CNT_W'(1));
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    if (last_reg) begin
                        cnt_next   = d_rounds;
                        state_next = (d_rounds == '0) ? ST_OUT : ST_FIN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                cmd.round = 1'b1;
                cnt_next  = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.capture   = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            fresh_reg    <= 1'b1;
            last_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            fresh_reg    <= fresh_next;
            last_reg     <= last_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `SH_ASSERT(a_capture_free, cmd.capture |-> (!m_tvalid_reg || m_tready), "hash overwritten")
    `SH_ASSERT(a_fin_cnt, (state_reg == ST_FIN || state_reg == ST_COMP) |-> (cnt_reg != '0), "round count ran out")
    `SH_ASSERT(a_ff_with_m, cmd.xor_ff |-> cmd.xor_m, "finalization mark without last fold")
    `SH_ASSERT(a_fresh_after_out, cmd.capture |=> fresh_reg, "message not closed after hash")
    `SH_ASSERT_ALWAYS(a_reset, !aresetn |=> (state_reg == ST_IDLE && !m_tvalid_reg), "reset not applied")

endmodule

// ===== src/siphash_keyed_hash.sv =====
// Keyed SipHash top level: controller and datapath.
//
// Input channel s_*: one 64-bit little-endian message word per beat. s_tlast marks
// the final beat, which carries 0 to 7 tail bytes (count in s_tdata[66:64]) and
// is padded with the message length mod 256 in the top byte.
// Output channel m_*: one 64-bit hash per message, after its last beat.
// Config port: cfg_we/cfg_index/cfg_wdata writes key_low, key_high,
// compress_rounds (c) and final_rounds (d); round counts saturate at 8.
// Throughput: one SipRound per cycle on the single round unit; the first round
// runs in the accept cycle, and the other rounds of a word follow it in ST_COMP.
// After the last beat is accepted come the remaining compression rounds, the d
// finalization rounds and the hash capture; s_tready is low while rounds run.
// If the receiver stalls, the hash waits in the output register; the next
// message is absorbed meanwhile, then its hash holds s_tready low until the register frees.
// Reset (aresetn low, synchronous): key zero, c = 2, d = 4, output empty,
// next beat starts a new message.
module siphash_keyed_hash (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [siphash_pkg::IDX_W-1:0]     cfg_index,
    input  logic [siphash_pkg::WORD_W-1:0]    cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [siphash_pkg::S_TDATA_W-1:0] s_tdata,   // [63:0] message_word, [66:64] tail_bytes
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [siphash_pkg::M_TDATA_W-1:0] m_tdata    // [63:0] hash_value
);
    import siphash_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    siphash_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    siphash_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata)
    );

endmodule
